[hdl/tdn_pkg.sv]
`default_nettype none
package tdn_pkg;

    localparam int DEF_FREQ_WIDTH = 32;

    // fractional quotient is below one second's worth of nanoseconds
    localparam int NS_Q_BITS = 30;

    localparam logic [31:0] TPS_RESET  = 32'd10000000;
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [63:0] MAX_WHOLE  = 64'd9223372036;
    localparam logic [63:0] MAX_POS_NS = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_FREQ = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef struct packed {
        logic neg;
        logic zero_freq;
        logic ovf;
    } t_flags;

endpackage
`default_nettype wire

[hdl/tdn_item_if.sv]
`default_nettype none
interface tdn_item_if;
    logic        valid;
    logic        ready;
    logic [63:0] anchor_ticks;
    logic [63:0] timestamp_ticks;

    modport source (output valid, output anchor_ticks, output timestamp_ticks, input ready);
    modport sink (input valid, input anchor_ticks, input timestamp_ticks, output ready);
endinterface
`default_nettype wire

[hdl/tdn_result_if.sv]
`default_nettype none
interface tdn_result_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] delta_ns;
    logic [1:0]         status;

    modport source (output valid, output delta_ns, output status, input ready);
    modport sink (input valid, input delta_ns, input status, output ready);
endinterface
`default_nettype wire

[hdl/tdn_cfg_if.sv]
`default_nettype none
interface tdn_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] ticks_per_second;

    modport source (output valid, output ticks_per_second, input ready);
    modport sink (input valid, input ticks_per_second, output ready);
endinterface
`default_nettype wire

[hdl/tdn_div_pipe.sv]
`default_nettype none
// restoring divider, one quotient bit per register stage
module tdn_div_pipe
    import tdn_pkg::*;
#(
    parameter int FW = DEF_FREQ_WIDTH,
    parameter int DW = 64,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [FW-1:0] i_divisor,
    input  wire logic [FW-1:0] i_rem,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [DW-1:0]      o_quotient,
    output logic [FW-1:0]      o_rem,
    output logic [SW-1:0]      o_side
);

    logic          r_valid [DW];
    logic [FW-1:0] r_rem   [DW];
    logic [DW-1:0] r_word  [DW];
    logic [SW-1:0] r_side  [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic          a_valid;
        logic [FW-1:0] a_rem;
        logic [DW-1:0] a_word;
        logic [SW-1:0] a_side;
        logic [FW:0]   t;
        logic          ge;
        logic [FW:0]   diff;
        logic [FW-1:0] n_rem;
        logic [DW-1:0] n_word;

        if (k == 0) begin : g_first
            assign a_valid = i_valid;
            assign a_rem   = i_rem;
            assign a_word  = i_dividend;
            assign a_side  = i_side;
        end else begin : g_next
            assign a_valid = r_valid[k-1];
            assign a_rem   = r_rem[k-1];
            assign a_word  = r_word[k-1];
            assign a_side  = r_side[k-1];
        end

        always_comb begin
            t      = {a_rem, a_word[DW-1]};
            ge     = (t >= {1'b0, i_divisor});
            diff   = t - {1'b0, i_divisor};
            n_rem  = ge ? diff[FW-1:0] : t[FW-1:0];
            n_word = {a_word[DW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= a_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_word[k] <= n_word;
                r_side[k] <= a_side;
            end
        end
    end

    assign o_valid    = r_valid[DW-1];
    assign o_quotient = r_word[DW-1];
    assign o_rem      = r_rem[DW-1];
    assign o_side     = r_side[DW-1];

endmodule
`default_nettype wire

[hdl/tick_delta_to_nanoseconds_unit.sv]
`default_nettype none
// item to result: difference, seconds divider, multiply, fraction divider, rounding, output
// throughput: one word per cycle when not stalled; set by the two bit-per-stage dividers
// every stage moves together, so a stall at the output holds the whole pipeline
// reset (synchronous, active low) empties the pipeline and loads the tick rate with 10 MHz
// configuration writes are always taken; the dividers read the live rate, so write only
// while the pipeline is empty
module tick_delta_to_nanoseconds_unit
    import tdn_pkg::*;
#(
    parameter int FREQ_WIDTH = DEF_FREQ_WIDTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tdn_item_if.sink     i_item,
    tdn_cfg_if.sink      i_cfg,
    tdn_result_if.source o_result
);

    localparam int FW = FREQ_WIDTH;
    localparam int PW = FW + NS_Q_BITS;   // width of rem * 1e9
    localparam int FLW = $bits(t_flags);

    // ---------------- configuration register ----------------
    logic [31:0]   r_tps;
    logic [FW-1:0] freq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (i_cfg.valid) begin
            r_tps <= i_cfg.ticks_per_second;
        end
    end

    assign i_cfg.ready = 1'b1;
    // only the low FREQ_WIDTH bits count (zero extended when wider)
    assign freq = FW'(r_tps);

    // ---------------- global pipeline enable ----------------
    logic r_out_valid;
    logic en;

    assign en           = !r_out_valid || o_result.ready;
    assign i_item.ready = en;

    // ---------------- stage 0: signed difference, magnitude ----------------
    logic        r_s0_valid;
    logic [63:0] r_s0_mag;
    t_flags      r_s0_flags;
    logic        neg_in;

    assign neg_in = i_item.timestamp_ticks < i_item.anchor_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_mag <= neg_in ? i_item.anchor_ticks - i_item.timestamp_ticks
                               : i_item.timestamp_ticks - i_item.anchor_ticks;
            r_s0_flags.neg       <= neg_in;
            r_s0_flags.zero_freq <= (freq == '0);
            r_s0_flags.ovf       <= 1'b0;
        end
    end

    // ---------------- divider 1: whole seconds and remainder ticks ----------------
    logic           d1_valid;
    logic [63:0]    d1_whole;
    logic [FW-1:0]  d1_rem;
    logic [FLW-1:0] d1_side;
    t_flags         d1_flags;

    tdn_div_pipe #(
        .FW (FW),
        .DW (64),
        .SW (FLW)
    ) u_div_sec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_s0_valid),
        .i_divisor  (freq),
        .i_rem      ('0),
        .i_dividend (r_s0_mag),
        .i_side     (r_s0_flags),
        .o_valid    (d1_valid),
        .o_quotient (d1_whole),
        .o_rem      (d1_rem),
        .o_side     (d1_side)
    );

    assign d1_flags = t_flags'(d1_side);

    // ---------------- multiply stage 1: partial products by 1e9 ----------------
    logic        r_m1_valid;
    logic [61:0] r_m1_plo;
    logic [61:0] r_m1_phi;
    logic [61:0] r_m1_wlo;
    logic [31:0] r_m1_whi;
    t_flags      r_m1_flags;
    logic [63:0] rem64;

    assign rem64 = 64'(d1_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (en) begin
            r_m1_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_plo <= 62'(rem64[31:0]) * 62'(NS_PER_SEC);
            r_m1_phi <= 62'(rem64[63:32]) * 62'(NS_PER_SEC);
            r_m1_wlo <= 62'(d1_whole[31:0]) * 62'(NS_PER_SEC);
            // whole is at most 34 bits when it does not overflow
            r_m1_whi <= 32'(d1_whole[33:32]) * 32'(NS_PER_SEC);
            r_m1_flags.neg       <= d1_flags.neg;
            r_m1_flags.zero_freq <= d1_flags.zero_freq;
            r_m1_flags.ovf       <= (d1_whole > MAX_WHOLE);
        end
    end

    // ---------------- multiply stage 2: sum partial products ----------------
    logic        r_m2_valid;
    logic [95:0] r_m2_prod;
    logic [63:0] r_m2_whole_ns;
    t_flags      r_m2_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (en) begin
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_prod     <= {2'b00, r_m1_phi, 32'd0} + 96'(r_m1_plo);
            r_m2_whole_ns <= {r_m1_whi, 32'd0} + 64'(r_m1_wlo);
            r_m2_flags    <= r_m1_flags;
        end
    end

    // ---------------- divider 2: fraction of a second in ns ----------------
    // rem < freq, so the top FW bits of rem*1e9 are already below freq
    logic [PW-1:0]        prod;
    logic                 d2_valid;
    logic [NS_Q_BITS-1:0] d2_q;
    logic [FW-1:0]        d2_rem;
    logic [64+FLW-1:0]    d2_side;
    logic [63:0]          d2_whole_ns;
    t_flags               d2_flags;

    assign prod = r_m2_prod[PW-1:0];

    tdn_div_pipe #(
        .FW (FW),
        .DW (NS_Q_BITS),
        .SW (64 + FLW)
    ) u_div_frac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_m2_valid),
        .i_divisor  (freq),
        .i_rem      (prod[PW-1:NS_Q_BITS]),
        .i_dividend (prod[NS_Q_BITS-1:0]),
        .i_side     ({r_m2_whole_ns, r_m2_flags}),
        .o_valid    (d2_valid),
        .o_quotient (d2_q),
        .o_rem      (d2_rem),
        .o_side     (d2_side)
    );

    assign d2_whole_ns = d2_side[64+FLW-1:FLW];
    assign d2_flags    = t_flags'(d2_side[FLW-1:0]);

    // ---------------- final stage 1: round half up and add ----------------
    logic        r_f1_valid;
    logic [63:0] r_f1_ns;
    t_flags      r_f1_flags;
    logic        round_up;

    // remainder at least half the divisor
    assign round_up = ({d2_rem, 1'b0} >= {1'b0, freq});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (en) begin
            r_f1_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_ns    <= d2_whole_ns + 64'(d2_q) + 64'(round_up);
            r_f1_flags <= d2_flags;
        end
    end

    // ---------------- final stage 2: range check, sign, output word ----------------
    logic signed [63:0] r_out_delta;
    logic [1:0]         r_out_status;
    t_status            status_c;
    logic [63:0]        delta_c;

    always_comb begin
        status_c = ST_OK;
        delta_c  = r_f1_flags.neg ? 64'd0 - r_f1_ns : r_f1_ns;
        if (r_f1_flags.zero_freq) begin
            status_c = ST_ZERO_FREQ;
            delta_c  = '0;
        end else if (r_f1_flags.ovf || (r_f1_ns > MAX_POS_NS)) begin
            status_c = ST_OVERFLOW;
            delta_c  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_delta  <= delta_c;
            r_out_status <= status_c;
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.delta_ns = r_out_delta;
    assign o_result.status   = r_out_status;

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import tdn_pkg::*;

    typedef struct {
        logic signed [63:0] delta_ns;
        t_status            status;
    } t_expected_delta;

    // keeps the tick rate and the queue of expected delta words
    class delta_scoreboard;
        logic [31:0]     tick_rate;
        t_expected_delta expected_q[$];
        int              errors;

        function new();
            tick_rate = TPS_RESET;
            errors    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // signed nanoseconds from anchor to stamp, rounding the fraction half up
        function t_expected_delta convert_ticks(logic [63:0] anchor, logic [63:0] stamp);
            t_expected_delta res;
            logic [63:0]  freq;
            logic [63:0]  mag;
            logic [63:0]  whole;
            logic [63:0]  rem;
            logic [127:0] num;
            logic [127:0] frac;
            logic [127:0] total;
            logic         neg;
            freq  = {32'd0, tick_rate};
            neg   = stamp < anchor;
            mag   = neg ? anchor - stamp : stamp - anchor;
            res.delta_ns = '0;
            res.status   = ST_OK;
            if (freq == 0) begin
                res.status = ST_ZERO_FREQ;
                return res;
            end
            whole = mag / freq;
            rem   = mag % freq;
            if (whole > MAX_WHOLE) begin
                res.status = ST_OVERFLOW;
                return res;
            end
            num   = {64'd0, rem} * 128'd2000000000 + {64'd0, freq};
            frac  = num / ({64'd0, freq} << 1);
            total = {64'd0, whole} * 128'd1000000000 + frac;
            if (total > {64'd0, MAX_POS_NS}) begin
                res.status = ST_OVERFLOW;
                return res;
            end
            res.delta_ns = neg ? -total[63:0] : total[63:0];
            return res;
        endfunction

        function void note_item(logic [63:0] anchor, logic [63:0] stamp);
            expected_q.push_back(convert_ticks(anchor, stamp));
        endfunction

        function void check_result(logic signed [63:0] delta_ns, logic [1:0] status);
            t_expected_delta exp_word;
            if (expected_q.size() == 0) begin
                $error("delta word with none expected: delta_ns %0d status %0d",
                       delta_ns, status);
                errors++;
                return;
            end
            exp_word = expected_q.pop_front();
            if (status !== exp_word.status) begin
                $error("status: expected %0d, actual %0d", exp_word.status, status);
                errors++;
            end
            if (delta_ns !== exp_word.delta_ns) begin
                $error("delta_ns: expected %0d, actual %0d", exp_word.delta_ns, delta_ns);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    tdn_item_if   item_ch();
    tdn_cfg_if    cfg_ch();
    tdn_result_if result_ch();

    tick_delta_to_nanoseconds_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch.sink),
        .i_cfg    (cfg_ch.sink),
        .o_result (result_ch.source)
    );

    delta_scoreboard board = new();

    // when set, neither side inserts gaps or stalls
    bit steady;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // all inputs known from time zero
    initial begin
        i_rst_n                 = 1'b0;
        item_ch.valid           = 1'b0;
        item_ch.anchor_ticks    = '0;
        item_ch.timestamp_ticks = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.ticks_per_second = '0;
        result_ch.ready         = 1'b0;
        steady                  = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function int gap_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls on the same pattern as the sender gaps
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else begin
            result_ch.ready <= 1'b1;
            stall_left      <= gap_len();
        end
    end

    // monitors: handshakes seen at the edge, before any update lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                board.tick_rate = cfg_ch.ticks_per_second;
            if (item_ch.valid && item_ch.ready)
                board.note_item(item_ch.anchor_ticks, item_ch.timestamp_ticks);
            if (result_ch.valid && result_ch.ready)
                board.check_result(result_ch.delta_ns, result_ch.status);
        end
    end

    task automatic send_item(logic [63:0] anchor, logic [63:0] stamp);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid           <= 1'b1;
        item_ch.anchor_ticks    <= anchor;
        item_ch.timestamp_ticks <= stamp;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    // pipeline is empty once every expected word is back
    task automatic drain_pipeline();
        item_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (110) @(posedge i_clk);
    endtask

    task automatic write_tick_rate(logic [31:0] rate);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.ticks_per_second <= rate;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random pairs: full range, small deltas, zero deltas, and deltas around the overflow edge
    task automatic send_random_items(int count);
        logic [63:0] anchor;
        logic [63:0] mag;
        int          kind;
        repeat (count) begin
            anchor = rand64();
            kind   = $urandom_range(0, 9);
            if (kind < 3)
                mag = rand64();
            else if (kind < 7)
                mag = rand64() >> $urandom_range(0, 63);
            else if (kind < 9)
                mag = {32'd0, board.tick_rate} * 64'd9223372036
                      + ((rand64() >> 30) % ({32'd0, board.tick_rate} * 2 + 1));
            else
                mag = 64'd0;
            if ($urandom_range(0, 1))
                send_item(anchor, anchor + mag);
            else
                send_item(anchor, anchor - mag);
        end
    endtask

    localparam logic [63:0] TEN_MHZ_EDGE = 64'd92233720360000000;

    initial begin
        logic [63:0] all_ones;
        all_ones = '1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset rate of 10 MHz: equal counts, extremes, deltas on both sides of the overflow edge
        steady = 1'b1;
        send_item(64'd0, 64'd0);
        send_item(all_ones, all_ones);
        send_item(64'd0, all_ones);
        send_item(all_ones, 64'd0);
        send_item(64'd0, TEN_MHZ_EDGE + 64'd9999999);
        send_item(TEN_MHZ_EDGE + 64'd9999999, 64'd0);
        send_item(64'd0, TEN_MHZ_EDGE + 64'd8547757);
        send_item(TEN_MHZ_EDGE + 64'd8547757, 64'd0);
        send_item(64'd100, 64'd101);
        send_item(64'd101, 64'd100);
        send_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        steady = 1'b0;
        send_random_items(200);

        // hold the sender until every word is back, then send a burst
        drain_pipeline();
        steady = 1'b1;
        send_random_items(40);
        steady = 1'b0;
        drain_pipeline();

        // zero rate fails every conversion
        write_tick_rate(32'd0);
        send_item(64'd0, 64'd1);
        send_item(all_ones, 64'd0);
        send_random_items(120);
        drain_pipeline();

        // one tick per second: no remainder ever
        write_tick_rate(32'd1);
        send_item(64'd0, 64'd9223372036);
        send_item(64'd0, 64'd9223372037);
        send_random_items(180);
        drain_pipeline();

        // exact half nanosecond rounds up
        write_tick_rate(32'd2000000000);
        send_item(64'd5, 64'd6);
        send_item(64'd6, 64'd5);
        send_random_items(200);
        drain_pipeline();

        // largest rate: top remainder rounds to a whole second
        write_tick_rate(32'hFFFF_FFFF);
        send_item(64'd0, 64'hFFFF_FFFE);
        send_item(64'hFFFF_FFFE, 64'd0);
        send_random_items(200);
        drain_pipeline();

        repeat (2) begin
            write_tick_rate($urandom);
            send_random_items(200);
            drain_pipeline();
        end

        write_tick_rate(TPS_RESET);
        send_random_items(150);
        drain_pipeline();

        if (board.errors == 0 && board.pending() == 0)
            $display("PASS tick_delta_to_nanoseconds_unit");
        else
            $display("FAIL tick_delta_to_nanoseconds_unit");
        $finish;
    end

    // generous limit on the whole run
    initial begin
        #20ms;
        $display("FAIL tick_delta_to_nanoseconds_unit");
        $finish;
    end

endmodule

`default_nettype wire
